>>> hdl/ulist_pkg.sv
// ----------------------------------------------------------------------------
// ulist_pkg
// Types, codes and sizes shared by the unique value list and its cells.
// ----------------------------------------------------------------------------
package ulist_pkg;

  localparam int DEPTH   = 64;
  localparam int COUNT_W = 7;

  typedef logic signed [31:0] value_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LIST   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_EMPTY     = 3'd5,
    ST_LISTED    = 3'd6
  } status_t;

  typedef struct packed {
    op_t    operation;
    value_t value;
  } req_t;

  typedef struct packed {
    status_t status;
    value_t  element;
    count_t  count;
    logic    last;
  } rsp_t;

  // What one cell hands to its neighbors.
  typedef struct packed {
    logic   valid;
    value_t entry;
  } link_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_MATCH,
    CELL_PUSH,
    CELL_PULL,
    CELL_ROTATE
  } cell_cmd_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_APPLY,
    FSM_LIST
  } fsm_t;

endpackage

>>> hdl/ulist_cell.sv
// ----------------------------------------------------------------------------
// ulist_cell
// One slot of the list: an entry, its valid flag and a registered match flag.
// ----------------------------------------------------------------------------
module ulist_cell (
  input  logic                clk,
  input  logic                rst,
  input  ulist_pkg::cell_cmd_t cmd,
  input  ulist_pkg::value_t   key,
  input  ulist_pkg::link_t    prev,
  input  ulist_pkg::link_t    next,
  input  ulist_pkg::value_t   head,
  input  logic                seen_in,
  output ulist_pkg::link_t    here,
  output logic                seen_out
);

  logic              valid;
  ulist_pkg::value_t entry;
  logic              hit;

  assign here     = '{valid: valid, entry: entry};
  // A match at or ahead of this cell means this cell closes the gap.
  assign seen_out = seen_in | hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (cmd)
        ulist_pkg::CELL_PUSH: valid <= prev.valid;
        ulist_pkg::CELL_PULL: begin
          if (seen_out) begin
            valid <= next.valid;
          end
        end
        default: valid <= valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      ulist_pkg::CELL_MATCH: hit <= valid && (entry == key);
      ulist_pkg::CELL_PUSH:  entry <= prev.entry;
      ulist_pkg::CELL_PULL: begin
        if (seen_out) begin
          entry <= next.entry;
        end
      end
      // Rotate within the occupied cells: the tail wraps to the head value.
      ulist_pkg::CELL_ROTATE: entry <= next.valid ? next.entry : head;
      default: entry <= entry;
    endcase
  end

endmodule

>>> hdl/unique_value_list.sv
// ----------------------------------------------------------------------------
// unique_value_list
// Ordered list of distinct signed values kept in a chain of cells.
// ----------------------------------------------------------------------------
// Insert and remove: in the accept cycle every cell compares its entry with
// the value, and once the output register is free the match flags decide the
// shift of the whole chain in one step. A list request rotates the chain's
// occupied cells once per result, and the head cell drives each listed entry
// in turn. A new request is taken once the previous one has loaded its final
// result into the output register, even while that result still waits to be
// taken.
module unique_value_list (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  ulist_pkg::req_t   req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output ulist_pkg::rsp_t   rsp
);

  ulist_pkg::fsm_t      state;
  ulist_pkg::fsm_t      state_next;
  ulist_pkg::op_t       op;
  ulist_pkg::value_t    key;
  ulist_pkg::count_t    count;
  ulist_pkg::count_t    count_next;
  ulist_pkg::count_t    idx;
  ulist_pkg::count_t    idx_next;
  ulist_pkg::rsp_t      rsp_next;
  ulist_pkg::cell_cmd_t cmd;
  ulist_pkg::value_t    cmp_key;
  logic                 load;
  logic                 out_free;
  logic                 any_hit;

  ulist_pkg::link_t link [ulist_pkg::DEPTH];
  logic             seen [ulist_pkg::DEPTH+1];

  assign seen[0] = 1'b0;
  assign any_hit = seen[ulist_pkg::DEPTH];
  assign cmp_key = req.value;
  assign out_free = !rsp_valid || !rsp_stall;

  for (genvar i = 0; i < ulist_pkg::DEPTH; i++) begin : g_cell
    ulist_pkg::link_t prev_l;
    ulist_pkg::link_t next_l;

    if (i == 0) begin : g_head
      assign prev_l = '{valid: 1'b1, entry: key};
    end else begin : g_body
      assign prev_l = link[i-1];
    end

    if (i == ulist_pkg::DEPTH - 1) begin : g_tail
      assign next_l = '{valid: 1'b0, entry: '0};
    end else begin : g_mid
      assign next_l = link[i+1];
    end

    ulist_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .key      (cmp_key),
      .prev     (prev_l),
      .next     (next_l),
      .head     (link[0].entry),
      .seen_in  (seen[i]),
      .here     (link[i]),
      .seen_out (seen[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ulist_pkg::FSM_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (load) begin
      rsp <= rsp_next;
    end
    if (state == ulist_pkg::FSM_IDLE && req_valid) begin
      op  <= req.operation;
      key <= req.value;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    cmd        = ulist_pkg::CELL_HOLD;
    load       = 1'b0;
    req_stall  = 1'b1;
    rsp_next   = '{status:  ulist_pkg::ST_EMPTY,
                   element: key,
                   count:   count,
                   last:    1'b1};

    case (state)
      ulist_pkg::FSM_IDLE: begin
        req_stall = 1'b0;
        // Compare every cycle while idle; the flags of the transfer cycle count.
        cmd = ulist_pkg::CELL_MATCH;
        if (req_valid) begin
          case (req.operation)
            ulist_pkg::OP_INSERT,
            ulist_pkg::OP_REMOVE,
            ulist_pkg::OP_LIST: state_next = ulist_pkg::FSM_APPLY;
            default:            state_next = ulist_pkg::FSM_IDLE;
          endcase
        end
      end

      ulist_pkg::FSM_APPLY: begin
        if (out_free) begin
          state_next = ulist_pkg::FSM_IDLE;
          load       = 1'b1;
          case (op)
            ulist_pkg::OP_INSERT: begin
              if (count == ulist_pkg::COUNT_W'(ulist_pkg::DEPTH)) begin
                rsp_next.status = ulist_pkg::ST_FULL;
              end else if (any_hit) begin
                rsp_next.status = ulist_pkg::ST_DUPLICATE;
              end else begin
                cmd             = ulist_pkg::CELL_PUSH;
                count_next      = count + 1'b1;
                rsp_next.status = ulist_pkg::ST_INSERTED;
                rsp_next.count  = count + 1'b1;
              end
            end
            ulist_pkg::OP_REMOVE: begin
              if (count == '0) begin
                rsp_next.status = ulist_pkg::ST_EMPTY;
              end else if (!any_hit) begin
                rsp_next.status = ulist_pkg::ST_NOT_FOUND;
              end else begin
                cmd             = ulist_pkg::CELL_PULL;
                count_next      = count - 1'b1;
                rsp_next.status = ulist_pkg::ST_REMOVED;
                rsp_next.count  = count - 1'b1;
              end
            end
            ulist_pkg::OP_LIST: begin
              if (count == '0) begin
                rsp_next.status  = ulist_pkg::ST_EMPTY;
                rsp_next.element = '0;
              end else begin
                // Hold the output slot; the walk starts next cycle.
                load       = 1'b0;
                idx_next   = '0;
                state_next = ulist_pkg::FSM_LIST;
              end
            end
            default: begin
              load = 1'b0;
            end
          endcase
        end
      end

      ulist_pkg::FSM_LIST: begin
        if (out_free) begin
          load             = 1'b1;
          cmd              = ulist_pkg::CELL_ROTATE;
          idx_next         = idx + 1'b1;
          rsp_next.status  = ulist_pkg::ST_LISTED;
          rsp_next.element = link[0].entry;
          rsp_next.last    = ((idx + 1'b1) == count);
          if ((idx + 1'b1) == count) begin
            state_next = ulist_pkg::FSM_IDLE;
          end
        end
      end

      default: begin
        state_next = ulist_pkg::FSM_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/ulist_check.sv
// ----------------------------------------------------------------------------
// ulist_check
// Port-level checks on the result stream of the unique value list.
// ----------------------------------------------------------------------------
module ulist_check (
  input logic            clk,
  input logic            rst,
  input logic            rsp_valid,
  input logic            rsp_stall,
  input ulist_pkg::rsp_t rsp
);

  logic rsp_xfer;
  assign rsp_xfer = rsp_valid && !rsp_stall;

  // A stalled result holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // Only listed entries may continue a burst.
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ulist_pkg::ST_LISTED |-> rsp.last)
    else $error("non-listed result without last");

  // A listing continues right after each non-final transfer, with the same count.
  a_list_burst: assert property (@(posedge clk) disable iff (rst)
    rsp_xfer && rsp.status == ulist_pkg::ST_LISTED && !rsp.last |=>
      rsp_valid && rsp.status == ulist_pkg::ST_LISTED &&
      rsp.count == $past(rsp.count))
    else $error("listing broken off");

  // Empty status comes only from an empty list.
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ulist_pkg::ST_EMPTY |-> rsp.count == '0)
    else $error("empty status with entries held");

  // Count never exceeds the depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.count <= ulist_pkg::COUNT_W'(ulist_pkg::DEPTH))
    else $error("count beyond depth");

endmodule

bind unique_value_list ulist_check u_ulist_check (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
